// ===== rtl/hcmd_pkg.sv =====
// Shared constants, codes and types for the header-code message decoder.
package hcmd_pkg;

	localparam int LENGTH_BITS_DEF = 3;
	localparam int TABLE_DEPTH_DEF = 256;

	localparam int CMD_W  = 2;
	localparam int KIND_W = 2;
	localparam int BYTE_W = 8;

	localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BIT     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RANGE = 2'd2;

	localparam logic [BYTE_W-1:0] HEADER_SIZE_RST = 8'd247;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [KIND_W-1:0] kind_t;

	// Result of one parsed code bit.
	typedef struct packed {
		logic  fire;  // this bit closes a field that yields a result
		kind_t kind;
	} hcmd_res_t;

endpackage

// ===== rtl/hcmd_table.sv =====
// Header character memory: one write port, one registered read port.
module hcmd_table #(
	parameter int AW = 8
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  hcmd_pkg::byte_t    wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output hcmd_pkg::byte_t    rdata
);
	import hcmd_pkg::*;

	byte_t mem [2**AW];
	byte_t rdata_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	assign rdata = rdata_s1;

endmodule

// ===== rtl/hcmd_parser.sv =====
// Bit-serial segment parser: length fields, keys and header entry index.
module hcmd_parser #(
	parameter int LENGTH_BITS = hcmd_pkg::LENGTH_BITS_DEF,
	parameter int TABLE_DEPTH = hcmd_pkg::TABLE_DEPTH_DEF,
	parameter int AW          = $clog2(TABLE_DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  restart,
	input  logic                  code_bit,
	input  hcmd_pkg::byte_t       header_size,
	output hcmd_pkg::hcmd_res_t   res,
	output logic [AW-1:0]         addr
);
	import hcmd_pkg::*;

	localparam int CW  = LENGTH_BITS;              // bit counter / key length
	localparam int EW  = (1 << LENGTH_BITS) - 1;   // longest key
	localparam int XA  = (EW + 1 > AW + 1) ? EW + 1 : AW + 1;
	localparam int XW  = (XA > BYTE_W + 1) ? XA : BYTE_W + 1;
	localparam logic [CW-1:0] LEN_CNT = CW'(LENGTH_BITS);

	logic          reading_key_q;
	logic [CW-1:0] bit_count_q;
	logic [EW-1:0] bit_shift_q;
	logic [CW-1:0] key_length_q;

	logic [CW-1:0] count_n;
	logic [EW-1:0] shift_n;
	logic [CW-1:0] len_field;
	logic [EW:0]   one_sh;
	logic [EW-1:0] ones;
	logic [EW-1:0] key_val;
	logic [EW:0]   entry;
	logic [XW-1:0] entry_x;
	logic          in_range;
	logic          len_done;
	logic          key_done;

	always_comb begin
		count_n   = bit_count_q + CW'(1);
		shift_n   = {bit_shift_q[EW-2:0], code_bit};
		len_field = shift_n[CW-1:0];
		len_done  = !reading_key_q && (count_n == LEN_CNT);
		key_done  = reading_key_q && (count_n == key_length_q);
		one_sh    = (EW+1)'(1) << key_length_q;
		ones      = EW'(one_sh - (EW+1)'(1));
		key_val   = shift_n & ones;
		// keys of length L start at 2^L - L - 1
		entry     = {1'b0, ones} - (EW+1)'(key_length_q) + {1'b0, key_val};
		entry_x   = XW'(entry);
		in_range  = (entry_x < XW'(header_size)) && (entry_x < XW'(TABLE_DEPTH));
		addr      = entry_x[AW-1:0];
	end

	always_comb begin
		res.fire = 1'b0;
		res.kind = KIND_CHAR;
		if (step) begin
			if (len_done && len_field == '0) begin
				res.fire = 1'b1;
				res.kind = KIND_END;
			end else if (key_done && key_val != ones) begin
				res.fire = 1'b1;
				res.kind = in_range ? KIND_CHAR : KIND_RANGE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_key_q <= 1'b0;
			bit_count_q   <= '0;
			bit_shift_q   <= '0;
			key_length_q  <= '0;
		end else if (restart) begin
			reading_key_q <= 1'b0;
			bit_count_q   <= '0;
			bit_shift_q   <= '0;
			key_length_q  <= '0;
		end else if (step) begin
			if (len_done) begin
				bit_count_q   <= '0;
				bit_shift_q   <= '0;
				key_length_q  <= len_field;
				reading_key_q <= (len_field != '0);
			end else if (key_done) begin
				bit_count_q <= '0;
				bit_shift_q <= '0;
				if (key_val == ones) begin
					// all-ones key closes the segment
					reading_key_q <= 1'b0;
					key_length_q  <= '0;
				end
			end else begin
				bit_count_q <= count_n;
				bit_shift_q <= shift_n;
			end
		end
	end

endmodule

// ===== rtl/header_code_message_decoder_core.sv =====
// Top level of the header-code message decoder: handshakes, read pipeline, output register.
//
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+-----
//  in      | in_valid, in_ready, command, entry_index,       | in
//          | entry_char, code_bit                            |
//  out     | out_valid, out_ready, kind, out_char            | out
//  cfg     | cfg_valid, cfg_ready, cfg_data (header_size)    | in
//
// One request is taken per cycle while in_ready is high; a result reaches the outputs
// through the table read in stage 1 and then the output register in stage 2.
// Throughput: one load or one lookup per cycle while in_ready is high.
// Reset clears the parser, the pipeline valids and header_size (to 247);
// the table itself holds garbage until loaded and gets no clearing pass.
// A stalled output holds stage 1 and its read data; in_ready drops only when
// both stage 1 and the output register hold results.
// TABLE_DEPTH must be a power of two: load indices wrap by dropping high bits.
module header_code_message_decoder_core #(
	parameter int LENGTH_BITS = hcmd_pkg::LENGTH_BITS_DEF,
	parameter int TABLE_DEPTH = hcmd_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input requests
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [hcmd_pkg::CMD_W-1:0]        command,
	input  hcmd_pkg::byte_t                   entry_index,
	input  hcmd_pkg::byte_t                   entry_char,
	input  logic                              code_bit,
	// results
	output logic                              out_valid,
	input  logic                              out_ready,
	output hcmd_pkg::kind_t                   kind,
	output hcmd_pkg::byte_t                   out_char,
	// header_size register write
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  hcmd_pkg::byte_t                   cfg_data
);
	import hcmd_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	byte_t         header_size_q;
	logic          in_acc;
	logic          do_load;
	logic          do_bit;
	logic          do_restart;
	hcmd_res_t     res;
	logic [AW-1:0] rd_addr;
	logic          rd_en;
	byte_t         rdata;

	// stage 1: table read in flight
	logic          v_s1;
	kind_t         kind_s1;
	// stage 2: output register
	logic          out_valid_q;
	kind_t         kind_q;
	byte_t         out_char_q;

	logic          out_adv;
	logic          s1_free;

	assign out_adv = !out_valid_q || out_ready;
	assign s1_free = !v_s1 || out_adv;
	assign in_ready = s1_free;
	assign in_acc   = in_valid && in_ready;

	assign do_load    = in_acc && (command == CMD_LOAD);
	assign do_bit     = in_acc && (command == CMD_BIT);
	assign do_restart = in_acc && (command == CMD_RESTART);

	// config register: always ready; the user must write it only while idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_size_q <= HEADER_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			header_size_q <= cfg_data;
		end
	end

	hcmd_parser #(
		.LENGTH_BITS (LENGTH_BITS),
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (do_bit),
		.restart     (do_restart),
		.code_bit    (code_bit),
		.header_size (header_size_q),
		.res         (res),
		.addr        (rd_addr)
	);

	// read only for in-range keys so a held result keeps its data
	assign rd_en = res.fire && (res.kind == KIND_CHAR);

	hcmd_table #(
		.AW (AW)
	) u_table (
		.clk   (clk),
		.we    (do_load),
		.waddr (AW'(entry_index)),
		.wdata (entry_char),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (res.fire) begin
			v_s1 <= 1'b1;
		end else if (out_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.fire) begin
			kind_s1 <= res.kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && v_s1) begin
			kind_q     <= kind_s1;
			out_char_q <= (kind_s1 == KIND_CHAR) ? rdata : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign out_char  = out_char_q;

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != KIND_CHAR |-> out_char_q == '0)
		else $error("non-character result carries a character");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !out_adv |=> v_s1 && $stable(kind_s1) && $stable(rdata))
		else $error("stalled lookup lost its data");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && out_valid_q)
		else $error("input stalled with free pipeline space");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && out_adv |=> out_valid_q)
		else $error("lookup result dropped on its way to output");

endmodule
